### src/cleb_pkg.sv
// shared types and codes of the cursor line edit buffer
package cleb_pkg;

    localparam int          BYTE_W  = 8;
    localparam int          OP_W    = 3;
    localparam logic [7:0]  NEWLINE = 8'd10;

    localparam logic [2:0] OP_TYPE  = 3'd0;
    localparam logic [2:0] OP_LEFT  = 3'd1;
    localparam logic [2:0] OP_RIGHT = 3'd2;
    localparam logic [2:0] OP_BACK  = 3'd3;
    localparam logic [2:0] OP_EOL   = 3'd4;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INS,
        CMD_DEL
    } cleb_kind_t;

    typedef struct packed {
        cleb_kind_t        kind;
        logic [BYTE_W-1:0] key;
    } cleb_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } cleb_state_t;

endpackage

### src/cleb_edit_if.sv
// request channel carrying one edit operation
interface cleb_edit_if
    import cleb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] key_byte;

    modport source (output valid, output op, output key_byte, input ready);
    modport sink   (input valid, input op, input key_byte, output ready);
endinterface

### src/cleb_text_if.sv
// request channel carrying one emitted character
interface cleb_text_if
    import cleb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

### src/cleb_cell.sv
// one character cell of the line, shifting with its neighbours
module cleb_cell
    import cleb_pkg::*;
#(
    parameter int CW    = 6,
    parameter int INDEX = 0
)(
    input  logic              clk,
    input  cleb_cmd_t         cmd,
    input  logic [CW-1:0]     pos,
    input  logic [BYTE_W-1:0] left,
    input  logic [BYTE_W-1:0] right,
    output logic [BYTE_W-1:0] data
);
    localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (cmd.kind)
            CMD_INS:
            begin
                if (MY_INDEX == pos)
                    data_next = cmd.key;
                else if (MY_INDEX > pos)
                    data_next = left;
            end
            CMD_DEL:
            begin
                // everything at or past the gap pulls from the right
                if (MY_INDEX >= pos)
                    data_next = right;
            end
            default:
                data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### src/cursor_line_edit_buffer.sv
// Keystroke line editor with a cursor, built as a row of character cells.
// The edit channel takes one operation a request: type, cursor left,
// cursor right, backspace or end of line. The line sits in CAPACITY cells in
// text order; a type opens a gap at the cursor by moving every later cell one
// place right, a backspace closes it by moving them one place left.
// After a type, left, right or backspace the edit channel stays ready, so a new
// edit is accepted in the very next cycle. Type on a full line, moves past an
// end of the line, and backspace at its start change nothing.
// End of line streams the line out of cell 0 on the text channel, shifting
// the whole row left by one cell per cycle while the receiver takes characters,
// then sends a newline with last set and empties the line; no edit is accepted
// until the newline is loaded.
// The text output is registered, so a stalled receiver holds the character
// on offer and stops the row; edits are taken while the newline waits.
// Reset empties the line at once; the cells need no clearing pass.
module cursor_line_edit_buffer
    import cleb_pkg::*;
#(
    parameter int CAPACITY = 32
)(
    input  logic        clk,
    input  logic        rst_n,
    cleb_edit_if.sink   edit,
    cleb_text_if.source text
);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    cleb_state_t state_reg, state_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] len_reg, len_next;
    logic          valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic          last_reg, last_next;

    cleb_cmd_t     cmd;
    logic [CW-1:0] cmd_pos;
    logic          accept;
    logic          load;

    logic [BYTE_W-1:0] cell_q [CAPACITY];

    assign edit.ready = (state_reg == ST_IDLE);
    assign accept = edit.valid && edit.ready;
    assign load   = (state_reg == ST_EMIT) && (!valid_reg || text.ready);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [BYTE_W-1:0] left_d;
            logic [BYTE_W-1:0] right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = edit.key_byte;
            end
            else
            begin : g_mid
                assign left_d = cell_q[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_end
                assign right_d = cell_q[gi];
            end
            else
            begin : g_inner
                assign right_d = cell_q[gi+1];
            end
            cleb_cell #(.CW(CW), .INDEX(gi)) u_cell (
                .clk   (clk),
                .cmd   (cmd),
                .pos   (cmd_pos),
                .left  (left_d),
                .right (right_d),
                .data  (cell_q[gi])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && edit.op == OP_EOL)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (load && len_reg == '0)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs, cell commands and cursor bookkeeping
    always_comb
    begin
        cmd.kind   = CMD_HOLD;
        cmd.key    = edit.key_byte;
        cmd_pos    = pos_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;

        if (text.ready)
            valid_next = 1'b0;

        if (accept)
        begin
            case (edit.op)
                OP_TYPE:
                    if (len_reg < CAP)
                    begin
                        cmd.kind = CMD_INS;
                        pos_next = pos_reg + 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                OP_LEFT:
                    if (pos_reg != '0)
                        pos_next = pos_reg - 1'b1;
                OP_RIGHT:
                    if (pos_reg < len_reg)
                        pos_next = pos_reg + 1'b1;
                OP_BACK:
                    if (pos_reg != '0)
                    begin
                        cmd.kind = CMD_DEL;
                        cmd_pos  = pos_reg - 1'b1;
                        pos_next = pos_reg - 1'b1;
                        len_next = len_reg - 1'b1;
                    end
                default:
                    cmd.kind = CMD_HOLD;
            endcase
        end

        if (load)
        begin
            valid_next = 1'b1;
            if (len_reg != '0)
            begin
                // pop cell 0 and pull the row left
                byte_next = cell_q[0];
                last_next = 1'b0;
                cmd.kind  = CMD_DEL;
                cmd_pos   = '0;
                len_next  = len_reg - 1'b1;
            end
            else
            begin
                byte_next = NEWLINE;
                last_next = 1'b1;
                pos_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            len_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign text.valid    = valid_reg;
    assign text.out_byte = byte_reg;
    assign text.last     = last_reg;

    a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> pos_reg <= len_reg)
        else $error("cursor beyond end of line");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CAP)
        else $error("line longer than capacity");

    a_eol_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && edit.op == OP_EOL |=> state_reg == ST_EMIT)
        else $error("end of line did not start emission");

    a_newline_closes: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(state_reg == ST_EMIT) |-> len_reg == '0 && pos_reg == '0
            && valid_reg && last_reg && byte_reg == NEWLINE)
        else $error("emission ended without newline or empty line");

endmodule

### verif/tb.sv
// self-checking bench for the cursor line edit buffer: a directed table, then random lines
module tb
    import cleb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_CAP   = 32;
    localparam int CYCLE_CAP  = 300000;
    localparam int EDIT_GOAL  = 480;
    localparam int QUIET_FROM = 200;
    localparam int QUIET_TO   = 330;

    // op codes the block must ignore
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              last;
    } text_t;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [BYTE_W-1:0]       key;
        logic                    pinned;
        logic [2:0]              pin_n;
        logic [0:3][BYTE_W-1:0]  pin_text;
    } edit_row_t;

    localparam int DIRECTED_N = 26;
    localparam edit_row_t DIRECTED [DIRECTED_N] = '{
        '{OP_EOL,     8'h00, 1'b1, 3'd0, 32'h0},
        '{OP_LEFT,    8'hA5, 1'b0, 3'd0, 32'h0},
        '{OP_RIGHT,   8'h5A, 1'b0, 3'd0, 32'h0},
        '{OP_BACK,    8'hFF, 1'b0, 3'd0, 32'h0},
        '{OP_EOL,     8'hFF, 1'b1, 3'd0, 32'h0},
        '{OP_TYPE,    8'h00, 1'b0, 3'd0, 32'h0},
        '{OP_TYPE,    8'hFF, 1'b0, 3'd0, 32'h0},
        '{OP_TYPE,    8'h0A, 1'b0, 3'd0, 32'h0},
        '{OP_EOL,     8'h00, 1'b1, 3'd3, {8'h00, 8'hFF, 8'h0A, 8'h00}},
        '{OP_TYPE,    8'h61, 1'b0, 3'd0, 32'h0},
        '{OP_TYPE,    8'h62, 1'b0, 3'd0, 32'h0},
        '{OP_LEFT,    8'h00, 1'b0, 3'd0, 32'h0},
        '{OP_TYPE,    8'h63, 1'b0, 3'd0, 32'h0},
        '{OP_LEFT,    8'h00, 1'b0, 3'd0, 32'h0},
        '{OP_LEFT,    8'h00, 1'b0, 3'd0, 32'h0},
        '{OP_LEFT,    8'h00, 1'b0, 3'd0, 32'h0},
        '{OP_LEFT,    8'hFF, 1'b0, 3'd0, 32'h0},
        '{OP_RIGHT,   8'h00, 1'b0, 3'd0, 32'h0},
        '{OP_BACK,    8'h00, 1'b0, 3'd0, 32'h0},
        '{OP_SPARE_5, 8'h55, 1'b0, 3'd0, 32'h0},
        '{OP_SPARE_6, 8'hAA, 1'b0, 3'd0, 32'h0},
        '{OP_SPARE_7, 8'hFF, 1'b0, 3'd0, 32'h0},
        '{OP_RIGHT,   8'h00, 1'b0, 3'd0, 32'h0},
        '{OP_RIGHT,   8'h00, 1'b0, 3'd0, 32'h0},
        '{OP_RIGHT,   8'h00, 1'b0, 3'd0, 32'h0},
        '{OP_EOL,     8'h00, 1'b0, 3'd0, 32'h0}
    };

    logic clk;
    logic rst_n;
    logic calm;
    int   errors;
    int   cycles;
    int   edits_counted;

    // shadow line: two stacks either side of the cursor
    logic [BYTE_W-1:0] left_chars  [LINE_CAP];
    logic [BYTE_W-1:0] right_chars [LINE_CAP];
    int                left_n;
    int                right_n;
    text_t             text_due [$];

    cleb_edit_if edit_ch ();
    cleb_text_if text_ch ();

    cursor_line_edit_buffer #(
        .CAPACITY (LINE_CAP)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .edit  (edit_ch.sink),
        .text  (text_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void apply_keystroke(input logic [OP_W-1:0] op,
                                            input logic [BYTE_W-1:0] key,
                                            ref text_t produced [$]);
        int i;
        case (op)
            OP_TYPE:
                if (left_n + right_n < LINE_CAP)
                begin
                    left_chars[left_n] = key;
                    left_n++;
                end
            OP_LEFT:
                if (left_n > 0)
                begin
                    left_n--;
                    right_chars[right_n] = left_chars[left_n];
                    right_n++;
                end
            OP_RIGHT:
                if (right_n > 0)
                begin
                    right_n--;
                    left_chars[left_n] = right_chars[right_n];
                    left_n++;
                end
            OP_BACK:
                if (left_n > 0)
                    left_n--;
            OP_EOL:
            begin
                for (i = 0; i < left_n; i++)
                    produced.push_back(text_t'{left_chars[i], 1'b0});
                for (i = right_n - 1; i >= 0; i--)
                    produced.push_back(text_t'{right_chars[i], 1'b0});
                produced.push_back(text_t'{NEWLINE, 1'b1});
                left_n  = 0;
                right_n = 0;
            end
            default:
                ;
        endcase
    endfunction

    task automatic send_edit(input edit_row_t row);
        text_t produced [$];
        int    k;
        while (!calm && $urandom_range(99) < 14)
        begin
            edit_ch.valid <= 1'b0;
            @(posedge clk);
        end
        edit_ch.valid    <= 1'b1;
        edit_ch.op       <= row.op;
        edit_ch.key_byte <= row.key;
        @(posedge clk);
        while (!edit_ch.ready)
            @(posedge clk);
        apply_keystroke(row.op, row.key, produced);
        if (row.pinned)
        begin
            for (k = 0; k < row.pin_n; k++)
                text_due.push_back(text_t'{row.pin_text[k], 1'b0});
            text_due.push_back(text_t'{NEWLINE, 1'b1});
        end
        else
        begin
            for (k = 0; k < produced.size(); k++)
                text_due.push_back(produced[k]);
        end
    endtask

    task automatic send_random(input logic [OP_W-1:0] op);
        send_edit(edit_row_t'{op, 8'($urandom), 1'b0, 3'd0, 32'h0});
        if (op <= OP_EOL)
            edits_counted++;
    endtask

    // hold requests back until the whole line has been read out
    task automatic drain_text();
        edit_ch.valid <= 1'b0;
        @(posedge clk);
        while (text_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [OP_W-1:0] pick_op(input int flavour);
        int r;
        r = $urandom_range(99);
        if (flavour == 1)
        begin
            // typing-heavy line, runs into the full buffer
            if (r < 88)
                return OP_TYPE;
            else if (r < 93)
                return OP_LEFT;
            else if (r < 96)
                return OP_RIGHT;
            return OP_BACK;
        end
        if (flavour == 2)
            return 3'($urandom_range(7));
        if (r < 50)
            return OP_TYPE;
        else if (r < 65)
            return OP_LEFT;
        else if (r < 78)
            return OP_RIGHT;
        else if (r < 92)
            return OP_BACK;
        else if (r < 95)
            return OP_SPARE_5;
        else if (r < 98)
            return OP_SPARE_6;
        return OP_SPARE_7;
    endfunction

    // result side: check each accepted character and stall at random
    always @(posedge clk)
    begin
        text_t want;
        if (!rst_n)
            text_ch.ready <= 1'b0;
        else
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                if (text_due.size() == 0)
                begin
                    $display("%0t: unexpected character %h last %b",
                             $time, text_ch.out_byte, text_ch.last);
                    errors++;
                end
                else
                begin
                    want = text_due.pop_front();
                    if (text_ch.out_byte !== want.ch)
                    begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, want.ch, text_ch.out_byte);
                        errors++;
                    end
                    if (text_ch.last !== want.last)
                    begin
                        $display("%0t: last expected %b actual %b",
                                 $time, want.last, text_ch.last);
                        errors++;
                    end
                end
            end
            text_ch.ready <= calm || ($urandom_range(99) >= 14);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_CAP)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int flavour;
        int len;
        int n;
        bit drained_mid;
        edits_counted    = 0;
        left_n           = 0;
        right_n          = 0;
        calm             = 1'b0;
        drained_mid      = 1'b0;
        rst_n            = 1'b0;
        edit_ch.valid    = 1'b0;
        edit_ch.op       = OP_TYPE;
        edit_ch.key_byte = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < DIRECTED_N; n++)
            send_edit(DIRECTED[n]);
        drain_text();

        while (edits_counted < EDIT_GOAL)
        begin
            calm <= (edits_counted >= QUIET_FROM && edits_counted < QUIET_TO);
            if (!drained_mid && edits_counted >= 100)
            begin
                drained_mid = 1'b1;
                drain_text();
            end
            n = $urandom_range(99);
            if (n < 15)
            begin
                flavour = 1;
                len     = $urandom_range(36, 48);
            end
            else if (n < 25)
            begin
                flavour = 2;
                len     = $urandom_range(1, 12);
            end
            else
            begin
                flavour = 0;
                len     = $urandom_range(0, 20);
            end
            for (n = 0; n < len; n++)
                send_random(pick_op(flavour));
            // noise lines end with a newline only half the time
            if (flavour != 2 || $urandom_range(1) == 1)
                send_random(OP_EOL);
        end

        edit_ch.valid <= 1'b0;
        while (text_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0 && text_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### cursor_line_edit_buffer.f
src/cleb_pkg.sv
src/cleb_edit_if.sv
src/cleb_text_if.sv
src/cleb_cell.sv
src/cursor_line_edit_buffer.sv
verif/tb.sv
